FILE: design/cpsf_pkg.sv
// Package for the column predicate scan filter: widths, codes, item types and
// the reciprocal constants for the 30 percent threshold. No dependencies.
`timescale 1ns / 1ps

package cpsf_pkg;

  localparam int CPSF_ROW_W      = 16;
  localparam int CPSF_VAL_W      = 64;
  localparam int CPSF_CNT_W      = 17;
  localparam int CPSF_IN_DATA_W  = 80;
  localparam int CPSF_IN_USER_W  = 2;
  localparam int CPSF_OUT_DATA_W = 72;
  localparam int CPSF_CFG_IDX_W  = 3;
  localparam int CPSF_FIFO_DEPTH = 2;

  // Count saturation point and number of list slots.
  localparam logic [CPSF_CNT_W-1:0] CPSF_MAX_ROWS  = 17'd65536;
  localparam logic [1:0]            CPSF_LIST_SIZE = 2'd3;

  // threshold = (row_total * 3) / 10, via 3 * floor(2^19 / 10) and one fix-up step.
  localparam int                CPSF_RECIP_SH = 19;
  localparam logic [17:0]       CPSF_RECIP3   = 18'd157284;
  localparam logic [CPSF_CNT_W-1:0] CPSF_NONE = 17'h1FFFF;

  typedef enum logic [3:0] {
    PRED_EQ      = 4'd0,
    PRED_NE      = 4'd1,
    PRED_GT      = 4'd2,
    PRED_LT      = 4'd3,
    PRED_GE      = 4'd4,
    PRED_LE      = 4'd5,
    PRED_BETWEEN = 4'd6,
    PRED_NBETWEEN = 4'd7,
    PRED_IN      = 4'd8,
    PRED_NIN     = 4'd9
  } pred_op_t;

  typedef enum logic [1:0] {
    COMB_PRED = 2'd0,
    COMB_AND  = 2'd1,
    COMB_OR   = 2'd2,
    COMB_MAP  = 2'd3
  } comb_mode_t;

  typedef enum logic [CPSF_CFG_IDX_W-1:0] {
    CFG_PRED_OP   = 3'd0,
    CFG_CMP_A     = 3'd1,
    CFG_CMP_B     = 3'd2,
    CFG_CMP_C     = 3'd3,
    CFG_LIST_CNT  = 3'd4,
    CFG_OFFSET    = 3'd5,
    CFG_COMBINE   = 3'd6,
    CFG_ROW_TOTAL = 3'd7
  } cfg_idx_t;

  // Predicate settings seen by the front end.
  typedef struct packed {
    logic [3:0]            pred_op;
    logic [CPSF_VAL_W-1:0] cmp_a;
    logic [CPSF_VAL_W-1:0] cmp_b;
    logic [CPSF_VAL_W-1:0] cmp_c;
    logic [1:0]            list_count;
    logic [CPSF_VAL_W-1:0] offset;
    logic [1:0]            combine;
  } filt_cfg_t;

  // One classified row as it travels from the front end to the back end.
  typedef struct packed {
    logic                  sel;
    logic [CPSF_ROW_W-1:0] row;
    logic                  last;
  } row_item_t;

endpackage

FILE: design/cpsf_front.sv
// Front end: accepts row beats, adds the offset and evaluates the predicate.
// Depends on cpsf_pkg.
`timescale 1ns / 1ps

module cpsf_front import cpsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  filt_cfg_t                 cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CPSF_ROW_W-1:0]     in_row,
  input  logic [CPSF_VAL_W-1:0]     in_raw,
  input  logic                      in_null,
  input  logic                      in_rowmap,
  input  logic                      in_last,
  output logic                      push_valid,
  output row_item_t                 push_item,
  input  logic                      push_ready
);

  logic                  valid_r, valid_nxt;
  row_item_t             item_r, item_nxt;
  logic [CPSF_VAL_W-1:0] val;
  logic                  eq_a, eq_b, eq_c, lt_va, lt_av, lt_bv;
  logic [1:0]            list_eff;
  logic                  in_list, pred, sel;
  logic                  accept;

  assign val   = in_raw + cfg.offset;
  assign eq_a  = (val == cfg.cmp_a);
  assign eq_b  = (val == cfg.cmp_b);
  assign eq_c  = (val == cfg.cmp_c);
  assign lt_va = ($signed(val) < $signed(cfg.cmp_a));
  assign lt_av = ($signed(cfg.cmp_a) < $signed(val));
  assign lt_bv = ($signed(cfg.cmp_b) < $signed(val));

  assign list_eff = (cfg.list_count > CPSF_LIST_SIZE) ? CPSF_LIST_SIZE : cfg.list_count;
  assign in_list  = ((list_eff >= 2'd1) && eq_a) || ((list_eff >= 2'd2) && eq_b) ||
                    ((list_eff >= 2'd3) && eq_c);

  always_comb begin
    unique case (cfg.pred_op)
      PRED_EQ:       pred = eq_a;
      PRED_NE:       pred = !eq_a;
      PRED_GT:       pred = lt_av;
      PRED_LT:       pred = lt_va;
      PRED_GE:       pred = !lt_va;
      PRED_LE:       pred = !lt_av;
      PRED_BETWEEN:  pred = !lt_va && !lt_bv;
      PRED_NBETWEEN: pred = lt_va || lt_bv;
      PRED_IN:       pred = in_list;
      PRED_NIN:      pred = !in_list;
      default:       pred = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cfg.combine)
      COMB_PRED: sel = pred;
      COMB_AND:  sel = in_rowmap && pred;
      COMB_OR:   sel = in_rowmap || pred;
      COMB_MAP:  sel = in_rowmap;
      default:   sel = 1'b0;
    endcase
  end

  // Hold the stage while the queue is full; refill as soon as it drains.
  assign in_ready = !valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt     = 1'b1;
      item_nxt.sel  = sel && !in_null;
      item_nxt.row  = in_row;
      item_nxt.last = in_last;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

FILE: design/cpsf_fifo.sv
// Short queue of classified rows between front and back end.
// Depends on cpsf_pkg.
`timescale 1ns / 1ps

module cpsf_fifo import cpsf_pkg::*; #(
  parameter int DEPTH = CPSF_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  row_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output row_item_t pop_item,
  input  logic      pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  row_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: design/cpsf_back.sv
// Back end: running match count, first and last match, threshold and the
// output register. Depends on cpsf_pkg.
`timescale 1ns / 1ps

module cpsf_back import cpsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [CPSF_CNT_W-1:0]     row_total,
  input  logic                      pop_valid,
  input  row_item_t                 pop_item,
  output logic                      pop_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_sel,
  output logic [CPSF_ROW_W-1:0]     out_row,
  output logic                      out_last,
  output logic [CPSF_CNT_W-1:0]     out_count,
  output logic [CPSF_CNT_W-1:0]     out_first,
  output logic [CPSF_CNT_W-1:0]     out_lastm,
  output logic                      out_keep
);

  localparam int PROD_W = CPSF_CNT_W + 18;
  localparam int X_W    = CPSF_CNT_W + 2;
  localparam int Q_W    = PROD_W - CPSF_RECIP_SH;

  // Threshold: estimate from the reciprocal product, then correct by one.
  logic [PROD_W-1:0]       prod_r;
  logic [X_W-1:0]          x_r;
  logic [Q_W-1:0]          q0;
  logic [X_W-1:0]          rem;
  logic [Q_W-1:0]          thresh_r, thresh_nxt;

  assign q0         = prod_r[PROD_W-1:CPSF_RECIP_SH];
  assign rem        = x_r - ((X_W'(q0) << 3) + (X_W'(q0) << 1));
  assign thresh_nxt = (rem >= X_W'(10)) ? q0 + 1'b1 : q0;

  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(row_total) * PROD_W'(CPSF_RECIP3);
    x_r      <= (X_W'(row_total) << 1) + X_W'(row_total);
    thresh_r <= thresh_nxt;
  end

  logic                  valid_r, valid_nxt;
  logic [CPSF_CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic                  fv_r, fv_nxt, fv_upd;
  logic [CPSF_ROW_W-1:0] first_r, first_nxt, first_upd;
  logic                  lv_r, lv_nxt, lv_upd;
  logic [CPSF_ROW_W-1:0] lastm_r, lastm_nxt, lastm_upd;
  logic                  pop;

  logic                  sel_r, last_r, keep_r;
  logic [CPSF_ROW_W-1:0] row_r;
  logic [CPSF_CNT_W-1:0] ocnt_r, ofirst_r, olastm_r;

  assign pop_ready = !valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    cnt_upd   = (pop_item.sel && (cnt_r < CPSF_MAX_ROWS)) ? cnt_r + 1'b1 : cnt_r;
    fv_upd    = fv_r || pop_item.sel;
    first_upd = (pop_item.sel && !fv_r) ? pop_item.row : first_r;
    lv_upd    = lv_r || pop_item.sel;
    lastm_upd = pop_item.sel ? pop_item.row : lastm_r;

    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    fv_nxt    = fv_r;
    first_nxt = first_r;
    lv_nxt    = lv_r;
    lastm_nxt = lastm_r;
    if (pop) begin
      valid_nxt = 1'b1;
      // Clear the running totals after the last row of a scan.
      if (pop_item.last) begin
        cnt_nxt = '0;
        fv_nxt  = 1'b0;
        lv_nxt  = 1'b0;
      end else begin
        cnt_nxt   = cnt_upd;
        fv_nxt    = fv_upd;
        first_nxt = first_upd;
        lv_nxt    = lv_upd;
        lastm_nxt = lastm_upd;
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
      fv_r    <= 1'b0;
      lv_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      fv_r    <= fv_nxt;
      lv_r    <= lv_nxt;
    end
    first_r <= first_nxt;
    lastm_r <= lastm_nxt;
    if (pop) begin
      sel_r    <= pop_item.sel;
      row_r    <= pop_item.row;
      last_r   <= pop_item.last;
      ocnt_r   <= cnt_upd;
      ofirst_r <= fv_upd ? {1'b0, first_upd} : CPSF_NONE;
      olastm_r <= lv_upd ? {1'b0, lastm_upd} : CPSF_NONE;
      keep_r   <= (cnt_upd >= CPSF_CNT_W'(thresh_r));
    end
  end

  assign out_valid = valid_r;
  assign out_sel   = sel_r;
  assign out_row   = row_r;
  assign out_last  = last_r;
  assign out_count = ocnt_r;
  assign out_first = ofirst_r;
  assign out_lastm = olastm_r;
  assign out_keep  = keep_r;

endmodule

FILE: design/column_predicate_scan_filter_core.sv
// Top level of the column predicate scan filter: configuration registers and
// the front end / queue / back end chain. Depends on cpsf_pkg, cpsf_front/fifo/back.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_tvalid/in_tready  | tdata row+value, tuser flags, tlast
//   out_    | output    | out_tvalid/out_tready| tdata result+summary, tlast
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// One row beat per cycle sustained while out_tready stays high; a row's result
// reaches out_ through the front register, the queue entry and the output register.
// The keep_full threshold is registered and follows row_total through prod_r.
// Reset (rst_n low at a clock edge) clears valids, queue pointers and totals;
// configuration registers return to their reset values.
// A stalled out_ fills the queue, then the front register; in_tready drops only then.
`timescale 1ns / 1ps

module column_predicate_scan_filter_core import cpsf_pkg::*; #(
  parameter int FIFO_DEPTH = CPSF_FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [CPSF_IN_DATA_W-1:0]   in_tdata,   // row_index, raw_value
  input  logic [CPSF_IN_USER_W-1:0]   in_tuser,   // is_null, rowmap_bit
  input  logic                        in_tlast,   // last_row_flag
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [CPSF_OUT_DATA_W-1:0]  out_tdata,  // row_selected, row_number,
                                                  // match_total, first_match_res,
                                                  // last_match, keep_full, zero pad
  output logic                        out_tlast,  // summary_valid
  input  logic                        cfg_we,
  input  logic [CPSF_CFG_IDX_W-1:0]   cfg_index,
  input  logic [CPSF_VAL_W-1:0]       cfg_wdata
);

  // Configuration registers.
  logic [3:0]            pred_op_r;
  logic [CPSF_VAL_W-1:0] cmp_a_r, cmp_b_r, cmp_c_r, offset_r;
  logic [1:0]            list_cnt_r, combine_r;
  logic [CPSF_CNT_W-1:0] row_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_op_r   <= PRED_EQ;
      cmp_a_r     <= '0;
      cmp_b_r     <= '0;
      cmp_c_r     <= '0;
      list_cnt_r  <= 2'd1;
      offset_r    <= '0;
      combine_r   <= COMB_PRED;
      row_total_r <= CPSF_MAX_ROWS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRED_OP:   pred_op_r   <= cfg_wdata[3:0];
        CFG_CMP_A:     cmp_a_r     <= cfg_wdata;
        CFG_CMP_B:     cmp_b_r     <= cfg_wdata;
        CFG_CMP_C:     cmp_c_r     <= cfg_wdata;
        CFG_LIST_CNT:  list_cnt_r  <= cfg_wdata[1:0];
        CFG_OFFSET:    offset_r    <= cfg_wdata;
        CFG_COMBINE:   combine_r   <= cfg_wdata[1:0];
        CFG_ROW_TOTAL: row_total_r <= cfg_wdata[CPSF_CNT_W-1:0];
        default:       pred_op_r   <= pred_op_r;
      endcase
    end
  end

  filt_cfg_t cfg;
  always_comb begin
    cfg.pred_op    = pred_op_r;
    cfg.cmp_a      = cmp_a_r;
    cfg.cmp_b      = cmp_b_r;
    cfg.cmp_c      = cmp_c_r;
    cfg.list_count = list_cnt_r;
    cfg.offset     = offset_r;
    cfg.combine    = combine_r;
  end

  logic      push_valid, push_ready, pop_valid, pop_ready;
  row_item_t push_item, pop_item;

  // Classify each row beat.
  cpsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_row     (in_tdata[CPSF_ROW_W-1:0]),
    .in_raw     (in_tdata[CPSF_ROW_W +: CPSF_VAL_W]),
    .in_null    (in_tuser[0]),
    .in_rowmap  (in_tuser[1]),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Decouple the two halves so each stalls on its own.
  cpsf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  logic                  o_sel, o_keep;
  logic [CPSF_ROW_W-1:0] o_row;
  logic [CPSF_CNT_W-1:0] o_count, o_first, o_lastm;

  // Advance the running totals and hold the result beat.
  cpsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_total (row_total_r),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sel   (o_sel),
    .out_row   (o_row),
    .out_last  (out_tlast),
    .out_count (o_count),
    .out_first (o_first),
    .out_lastm (o_lastm),
    .out_keep  (o_keep)
  );

  assign out_tdata = {3'b000, o_keep, o_lastm, o_first, o_count, o_row, o_sel};

endmodule

FILE: design/cpsf_checker.sv
// Port-level checks for the column predicate scan filter, bound to the top level.
// Depends on cpsf_pkg and column_predicate_scan_filter_core.
`timescale 1ns / 1ps

module cpsf_checker import cpsf_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [CPSF_OUT_DATA_W-1:0]  out_tdata,
  input logic                        out_tlast
);

  logic [CPSF_CNT_W-1:0] count, first_m, last_m;
  logic [CPSF_ROW_W-1:0] row;

  assign row     = out_tdata[16:1];
  assign count   = out_tdata[33:17];
  assign first_m = out_tdata[50:34];
  assign last_m  = out_tdata[67:51];

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // No match so far exactly when first and last match read as none.
  a_none_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((count == '0) == (first_m == CPSF_NONE)) &&
                   ((count == '0) == (last_m == CPSF_NONE)))
    else $error("match count disagrees with first/last match");

  // A selected row is the last match and makes the count nonzero.
  a_sel_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (last_m == {1'b0, row}) && (count != '0))
    else $error("selected row not reported as last match");

  // No result beat right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result valid out of reset");

endmodule

bind column_predicate_scan_filter_core cpsf_checker u_cpsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
